@@ rtl/core/itda_pkg.sv @@
package itda_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	localparam int CHAR_W  = 6;
	localparam int DIGIT_W = 4;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;

	// Long division by ten works on chunks of the magnitude, most significant first.
	// The partial dividend is {remainder, chunk}, always below ten times 2^CHUNK_W.
	localparam int CHUNK_W = 16;
	localparam int PART_W  = DIGIT_W + CHUNK_W;
	localparam int PROD_W  = 2 * PART_W;

	// ceil(2^23 / 10): exact quotient for every partial dividend below 10 * 2^16
	localparam logic [PART_W-1:0] DIV_RECIP = 20'd838861;
	localparam int DIV_SHIFT = 23;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_PREP,
		ST_SIGN,
		ST_EMIT
	} state_t;

endpackage

@@ rtl/core/itda_value_if.sv @@
interface itda_value_if #(
	parameter int VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/core/itda_char_if.sv @@
interface itda_char_if;
	logic                           valid;
	logic                           ready;
	logic [itda_pkg::CHAR_W-1:0]    character;
	logic                           last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

@@ rtl/core/itda_div10.sv @@
module itda_div10 (
	input  logic [itda_pkg::DIGIT_W-1:0] rem_in,
	input  logic [itda_pkg::CHUNK_W-1:0] chunk,
	output logic [itda_pkg::CHUNK_W-1:0] quo,
	output logic [itda_pkg::DIGIT_W-1:0] rem_out
);

	logic [itda_pkg::PART_W-1:0] part;
	logic [itda_pkg::PROD_W-1:0] prod;
	logic [itda_pkg::PART_W-1:0] tenfold;
	logic [itda_pkg::PART_W-1:0] diff;

	assign part = {rem_in, chunk};
	assign prod = itda_pkg::PROD_W'(part) * itda_pkg::PROD_W'(itda_pkg::DIV_RECIP);
	assign quo  = prod[itda_pkg::DIV_SHIFT +: itda_pkg::CHUNK_W];

	// quotient times ten as two shifted adds
	assign tenfold = (itda_pkg::PART_W'(quo) << 3) + (itda_pkg::PART_W'(quo) << 1);
	assign diff    = part - tenfold;
	assign rem_out = diff[itda_pkg::DIGIT_W-1:0];

endmodule

@@ rtl/core/itda_digit_store.sv @@
module itda_digit_store #(
	parameter int DEPTH = 10
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  logic [itda_pkg::DIGIT_W-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(DEPTH)-1:0]     rd_addr,
	output logic [itda_pkg::DIGIT_W-1:0] rd_data
);

	logic [itda_pkg::DIGIT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/integer_to_decimal_ascii.sv @@
// channel  | modport | payload          | role
// ---------+---------+------------------+-------------------------------------
// number   | sink    | value            | signed integer, one per conversion
// text     | source  | character, last  | ASCII '-' or digit, last marks end
//
// Each digit is one pass of the shared divide-by-ten unit over the magnitude,
// one 16-bit chunk at a time, most significant first. Once all digits are
// stored, the characters follow, one character per cycle while text is ready.
// number.ready is high only between conversions; a stall on text holds the
// output register and the sequencer in its sign and emit states. Reset
// clears the sequencer and output valid.
module integer_to_decimal_ascii #(
	parameter int VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	itda_value_if.sink   number,
	itda_char_if.source  text
);

	localparam int DEPTH  = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int NCHUNK = (VALUE_WIDTH + itda_pkg::CHUNK_W - 1) / itda_pkg::CHUNK_W;
	localparam int PW     = NCHUNK * itda_pkg::CHUNK_W;
	localparam int KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

	itda_pkg::state_t state_q, state_next;

	logic [PW-1:0]                mag_q;
	logic [KW-1:0]                chunk_q;
	logic [itda_pkg::DIGIT_W-1:0] rem_q;
	logic [CW-1:0]                count_q;
	logic [AW-1:0]                idx_q;
	logic                         neg_q;

	logic                         out_valid_q;
	logic [itda_pkg::CHAR_W-1:0]  out_char_q;
	logic                         out_last_q;

	logic [VALUE_WIDTH-1:0]       val_raw;
	logic                         val_neg;
	logic [VALUE_WIDTH-1:0]       val_abs;

	logic [itda_pkg::CHUNK_W-1:0] quo;
	logic [itda_pkg::DIGIT_W-1:0] rem_out;
	logic [PW-1:0]                mag_next;
	logic                         digit_done;
	logic                         quot_zero;

	logic                         out_free;
	logic                         in_ready;
	logic                         accept;
	logic                         wr_en;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic [itda_pkg::DIGIT_W-1:0] rd_data;
	logic                         load_out;
	logic [itda_pkg::CHAR_W-1:0]  load_char;
	logic                         load_last;

	assign val_raw = number.value;
	assign val_neg = val_raw[VALUE_WIDTH-1];
	assign val_abs = val_neg ? (~val_raw + VALUE_WIDTH'(1)) : val_raw;

	itda_div10 u_div10 (
		.rem_in  (rem_q),
		.chunk   (mag_q[PW-1 -: itda_pkg::CHUNK_W]),
		.quo     (quo),
		.rem_out (rem_out)
	);

	// quotient chunks shift in from the bottom as the dividend shifts out the top
	assign mag_next   = (mag_q << itda_pkg::CHUNK_W) | PW'(quo);
	assign digit_done = (chunk_q == '0);
	assign quot_zero  = (mag_next == '0);

	itda_digit_store #(.DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (rem_out),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_free     = !out_valid_q || text.ready;
	assign accept       = number.valid && in_ready;
	assign number.ready = in_ready;
	assign text.valid     = out_valid_q;
	assign text.character = out_char_q;
	assign text.last      = out_last_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			itda_pkg::ST_IDLE: begin
				if (number.valid) begin
					state_next = itda_pkg::ST_DIVIDE;
				end
			end
			itda_pkg::ST_DIVIDE: begin
				if (digit_done && quot_zero) begin
					state_next = itda_pkg::ST_PREP;
				end
			end
			itda_pkg::ST_PREP: begin
				state_next = neg_q ? itda_pkg::ST_SIGN : itda_pkg::ST_EMIT;
			end
			itda_pkg::ST_SIGN: begin
				if (out_free) begin
					state_next = itda_pkg::ST_EMIT;
				end
			end
			itda_pkg::ST_EMIT: begin
				if (out_free && idx_q == '0) begin
					state_next = itda_pkg::ST_IDLE;
				end
			end
			default: state_next = itda_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		load_out  = 1'b0;
		load_char = itda_pkg::ASCII_ZERO + itda_pkg::CHAR_W'(rd_data);
		load_last = (idx_q == '0);
		case (state_q)
			itda_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			itda_pkg::ST_DIVIDE: begin
				wr_en = digit_done;
			end
			itda_pkg::ST_PREP: begin
				rd_en = 1'b1;
			end
			itda_pkg::ST_SIGN: begin
				load_out  = out_free;
				load_char = itda_pkg::ASCII_MINUS;
				load_last = 1'b0;
			end
			itda_pkg::ST_EMIT: begin
				load_out = out_free;
				// fetch the next lower digit as this one moves to the output
				rd_en    = out_free && (idx_q != '0);
				rd_addr  = idx_q - AW'(1);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itda_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
		end else begin
			state_q <= state_next;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				neg_q   <= val_neg;
				mag_q   <= PW'(val_abs);
				count_q <= '0;
			end else if (state_q == itda_pkg::ST_DIVIDE) begin
				mag_q <= mag_next;
				if (digit_done) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chunk_q <= KW'(NCHUNK - 1);
			rem_q   <= '0;
		end else if (state_q == itda_pkg::ST_DIVIDE) begin
			if (digit_done) begin
				chunk_q <= KW'(NCHUNK - 1);
				rem_q   <= '0;
				idx_q   <= count_q[AW-1:0];
			end else begin
				chunk_q <= chunk_q - KW'(1);
				rem_q   <= rem_out;
			end
		end else if (state_q == itda_pkg::ST_EMIT && out_free && idx_q != '0) begin
			idx_q <= idx_q - AW'(1);
		end
		if (load_out) begin
			out_char_q <= load_char;
			out_last_q <= load_last;
		end
	end

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid |-> (text.character == itda_pkg::ASCII_MINUS ||
			(text.character >= itda_pkg::ASCII_ZERO &&
			 text.character <= itda_pkg::ASCII_NINE)))
		else $error("character outside '-' and digits");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.character == itda_pkg::ASCII_MINUS |-> !text.last)
		else $error("sign marked as final character");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("digit count beyond store depth");

	a_accept_starts_divide: assert property (@(posedge clk) disable iff (!arst_n)
		number.valid && number.ready |=> state_q == itda_pkg::ST_DIVIDE)
		else $error("transfer on number did not start a conversion");

endmodule
